// ----- hdl/c3zp_pkg.sv -----
package c3zp_pkg;

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 8;
    localparam int TAPS      = 3;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int SIZE_W    = 6;
    localparam int VALUE_W   = 20;
    localparam int PROD_W    = 17;

    // Frame position spans size*size pixel steps plus size+1 drain steps; the input side wraps at 10 bits
    localparam int POS_W     = 11;
    localparam int DIVD_W    = 10;
    localparam int DIV_CNT_W = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF_TOP    = 2'd0,
        CFG_COEFF_MID    = 2'd1,
        CFG_COEFF_BOTTOM = 2'd2,
        CFG_SIZE         = 2'd3
    } cfg_index_t;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Per-step control carried down the window pipeline
    typedef struct packed {
        logic emit;
        logic last;
        logic pad_top;
        logic pad_bottom;
        logic pad_left;
        logic pad_right;
    } tap_ctl_t;

endpackage

// ----- hdl/conv3x3_zero_pad_stream.sv -----
// 3x3 zero-padded 2D convolution over a square image streamed in raster order.
// Input channel: pixel with in_valid/in_ready, one pixel per beat, one beat per cycle while in_ready is high.
// Output channel: value/frame_end with out_valid/out_ready; frame_end marks the last
// result of a frame. Config port: cfg_we/cfg_index/cfg_data, written while idle.
// Result k starts down the pipeline with the step of pixel k+size+1; the
// pipeline is row-store read, window shift, nine products, sum into the output buffer.
// Throughput is one pixel per cycle while in_ready is high; the row store has separate read and write ports.
// The last pixel of a frame starts a drain of size+1 zero steps, one per cycle unless the output buffer
// is full, during which in_ready is low; the counters then wrap for the next frame.
// A write to the size register holds in_ready low while a bit-serial
// divider rebuilds the row and column of the current position.
// Reset clears the counters, the window and the coefficients and sets the size to 32.
// The row stores are not cleared; pixels never written are masked by the padding.
// When the receiver stalls, a two-entry output buffer takes one more beat; the stall
// holds in_ready low only while its second entry is occupied.
module conv3x3_zero_pad_stream
    import c3zp_pkg::*;
#(
    parameter int IMAGE_SIZE = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [PIX_W-1:0]          pixel,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic signed [VALUE_W-1:0] value,
    output logic                      frame_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int COL_W = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;

    // Configuration
    logic [CFG_W-1:0]  coef_reg [TAPS];
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] n;
    logic [POS_W-1:0]  n_ext;
    logic [POS_W-1:0]  nn;
    logic [POS_W-1:0]  nn_m1_reg;
    logic [POS_W-1:0]  nn_pn_reg;

    // Position counters
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             drain_reg;

    // Divider
    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [DIVD_W-1:0]    quo_reg;
    logic [SIZE_W-1:0]    rem_shift;
    logic                 rem_ge;
    logic [SIZE_W-1:0]    rem_next;
    logic [DIVD_W-1:0]    quo_next;

    // Step issue
    logic             en;
    logic             issue;
    pix_t             step_px;
    logic             col_wrap;
    logic [COL_W-1:0] col_inc;
    logic [POS_W-1:0] row_inc;
    logic             frame_done;
    logic             drain_start;
    logic             past_first;
    logic [POS_W-1:0] kr;
    tap_ctl_t         a_ctl;

    // Stage 1: row-store read
    logic                 s1_valid_reg;
    tap_ctl_t             s1_ctl_reg;
    pix_t                 s1_px_reg;
    logic [COL_W-1:0]     s1_addr_reg;
    logic [2*PIX_W-1:0]   rd_data;
    logic                 fwd_reg;
    logic [2*PIX_W-1:0]   fwd_data_reg;
    pix_t                 up_now;
    pix_t                 mid_now;

    // Stage 2: window
    pix_t     win_reg [TAPS][TAPS];
    logic     s2_valid_reg;
    tap_ctl_t s2_ctl_reg;

    // Stage 3: products
    prod_t prod_reg [TAPS][TAPS];
    logic  s3_valid_reg;
    logic  s3_last_reg;
    logic signed [VALUE_W-1:0] sum;

    // Output buffer
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      frame_end_reg;
    logic                      skid_valid_reg;
    logic signed [VALUE_W-1:0] skid_value_reg;
    logic                      skid_last_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            size_reg    <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_COEFF_TOP:    coef_reg[0] <= cfg_data;
                CFG_COEFF_MID:    coef_reg[1] <= cfg_data;
                CFG_COEFF_BOTTOM: coef_reg[2] <= cfg_data;
                CFG_SIZE:         size_reg    <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp size to 1..IMAGE_SIZE
    always_comb
    begin
        if (size_reg == '0)
        begin
            n = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(IMAGE_SIZE))
        begin
            n = SIZE_W'(IMAGE_SIZE);
        end
        else
        begin
            n = size_reg;
        end
    end

    assign n_ext = POS_W'(n);
    assign nn    = n_ext * n_ext;

    // Frame bounds, settled during the divider pass after a size write
    always_ff @(posedge clk)
    begin
        nn_m1_reg <= nn - POS_W'(1);
        nn_pn_reg <= nn + n_ext;
    end

    // Bit-serial divide of the position by the size
    assign rem_shift = {rem_reg[SIZE_W-2:0], quo_reg[DIVD_W-1]};
    assign rem_ge    = (rem_shift >= n);
    assign rem_next  = rem_ge ? (rem_shift - n) : rem_shift;
    assign quo_next  = {quo_reg[DIVD_W-2:0], rem_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            div_cnt_reg <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_SIZE))
        begin
            busy_reg    <= 1'b1;
            div_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (div_cnt_reg == DIV_CNT_W'(DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_we && (cfg_index == CFG_SIZE))
        begin
            rem_reg <= '0;
            quo_reg <= pos_reg[DIVD_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Issue one step per cycle unless the output buffer or the divider stalls: an input pixel or a drain step
    assign en       = !skid_valid_reg;
    assign in_ready = en && !drain_reg && !busy_reg;
    assign issue    = en && !busy_reg && (drain_reg || in_valid);
    assign step_px  = drain_reg ? '0 : pixel;

    assign col_wrap    = ((SIZE_W'(col_reg) + SIZE_W'(1)) == n);
    assign col_inc     = col_wrap ? '0 : (col_reg + COL_W'(1));
    assign row_inc     = col_wrap ? (row_reg + POS_W'(1)) : row_reg;
    assign frame_done  = (pos_reg >= nn_pn_reg);
    assign drain_start = !drain_reg && (pos_reg >= nn_m1_reg) && !frame_done;

    // Result position is one before this step's column, one row further up
    assign past_first = (row_reg > POS_W'(1)) || ((row_reg == POS_W'(1)) && (col_reg != '0));
    assign kr         = (col_reg != '0) ? (row_reg - POS_W'(1)) : (row_reg - POS_W'(2));

    always_comb
    begin
        a_ctl.emit       = past_first && (kr < n_ext);
        a_ctl.pad_top    = (kr == '0);
        a_ctl.pad_bottom = (kr == (n_ext - POS_W'(1)));
        a_ctl.pad_right  = (col_reg == '0);
        a_ctl.pad_left   = (col_reg == COL_W'(1)) || ((col_reg == '0) && (n == SIZE_W'(1)));
        a_ctl.last       = a_ctl.pad_bottom && a_ctl.pad_right;
    end

    // Advance position, row and column; wrap at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else if (busy_reg && (div_cnt_reg == DIV_CNT_W'(DIVD_W - 1)))
        begin
            row_reg <= POS_W'(quo_next);
            col_reg <= rem_next[COL_W-1:0];
        end
        else if (issue)
        begin
            if (frame_done)
            begin
                pos_reg   <= '0;
                row_reg   <= '0;
                col_reg   <= '0;
                drain_reg <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_reg + POS_W'(1);
                row_reg   <= row_inc;
                col_reg   <= col_inc;
                drain_reg <= drain_reg || drain_start;
            end
        end
    end

    // Row stores: upper pixel in the high byte, middle pixel in the low byte
    c3zp_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (IMAGE_SIZE)
    ) u_row_ram (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata ({mid_now, s1_px_reg}),
        .re    (issue),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    // Forward the write of the previous step when it hits the same column
    assign up_now  = fwd_reg ? fwd_data_reg[2*PIX_W-1:PIX_W] : rd_data[2*PIX_W-1:PIX_W];
    assign mid_now = fwd_reg ? fwd_data_reg[PIX_W-1:0]       : rd_data[PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= issue;
            fwd_reg      <= s1_valid_reg && issue && (s1_addr_reg == col_reg);
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1 payload and the control carried into stages 2 and 3
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg   <= a_ctl;
            s1_px_reg    <= step_px;
            s1_addr_reg  <= col_reg;
            fwd_data_reg <= {mid_now, s1_px_reg};
            s2_ctl_reg   <= s1_ctl_reg;
            s3_last_reg  <= s2_ctl_reg.last;
        end
    end

    // Shift the window one column left and load the new right column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TAPS; s++)
            begin
                for (int t = 0; t < TAPS; t++)
                begin
                    win_reg[s][t] <= '0;
                end
            end
        end
        else if (en && s1_valid_reg)
        begin
            for (int s = 0; s < TAPS; s++)
            begin
                win_reg[s][0] <= win_reg[s][1];
                win_reg[s][1] <= win_reg[s][2];
            end
            win_reg[0][2] <= up_now;
            win_reg[1][2] <= mid_now;
            win_reg[2][2] <= s1_px_reg;
        end
    end

    // Nine products against the rotated kernel, zero where padded
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < TAPS; s++)
            begin
                for (int t = 0; t < TAPS; t++)
                begin
                    if (((s == 0) && s2_ctl_reg.pad_top) ||
                        ((s == TAPS - 1) && s2_ctl_reg.pad_bottom) ||
                        ((t == 0) && s2_ctl_reg.pad_left) ||
                        ((t == TAPS - 1) && s2_ctl_reg.pad_right))
                    begin
                        prod_reg[s][t] <= '0;
                    end
                    else
                    begin
                        prod_reg[s][t] <=
                            $signed(coef_reg[TAPS-1-s][COEF_W*(TAPS-1-t) +: COEF_W]) *
                            $signed({1'b0, win_reg[s][t]});
                    end
                end
            end
        end
    end

    // Sum the products
    always_comb
    begin
        sum = '0;
        for (int s = 0; s < TAPS; s++)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                sum = sum + VALUE_W'(prod_reg[s][t]);
            end
        end
    end

    // Output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s3_valid_reg;
        end
        else if (s3_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                value_reg     <= skid_value_reg;
                frame_end_reg <= skid_last_reg;
            end
        end
        else if (!out_valid_reg || out_ready)
        begin
            value_reg     <= sum;
            frame_end_reg <= s3_last_reg;
        end
        else
        begin
            skid_value_reg <= sum;
            skid_last_reg  <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- hdl/c3zp_ram.sv -----
module c3zp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/c3zp_checker.sv -----
module c3zp_checker
    import c3zp_pkg::*;
#(
    parameter int IMAGE_SIZE = 32
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic [PIX_W-1:0]          pixel,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic signed [VALUE_W-1:0] value,
    input logic                      frame_end,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      cfg_we,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic [CFG_W-1:0]          cfg_data
);

    localparam int DEF_N  = (IMAGE_SIZE < 32) ? IMAGE_SIZE : 32;
    localparam int DEF_NN = DEF_N * DEF_N;

    logic [POS_W-1:0] res_cnt_reg;
    logic             size_written_reg;
    logic             out_beat;

    assign out_beat = out_valid && out_ready;

    // Count result beats within the frame; note any size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg      <= '0;
            size_written_reg <= 1'b0;
        end
        else
        begin
            if (out_beat)
            begin
                res_cnt_reg <= frame_end ? '0 : (res_cnt_reg + POS_W'(1));
            end
            if (cfg_we && (cfg_index == CFG_SIZE))
            begin
                size_written_reg <= 1'b1;
            end
        end
    end

    // Output channel is empty right after reset
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("out_valid high right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(frame_end)))
        else $error("stalled result beat changed");

    // Size write blocks input while the position is re-divided
    a_size_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == CFG_SIZE)) |=> !in_ready)
        else $error("input accepted during size recompute");

    // At the default size a frame has exactly size*size results
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !size_written_reg) |->
            (frame_end == (res_cnt_reg == POS_W'(DEF_NN - 1))))
        else $error("frame_end not on the last result of the frame");

endmodule

bind conv3x3_zero_pad_stream c3zp_checker #(
    .IMAGE_SIZE (IMAGE_SIZE)
) u_c3zp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pixel     (pixel),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
